[hw/rtl/stt_pkg.sv]
package stt_pkg;

    localparam int PositionBits  = 16;
    localparam int MaxKeywordLen = 8;
    localparam int MaxTokens     = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef enum logic [5:0] {
        KIND_ADD, KIND_MINUS, KIND_MODULE, KIND_POWER, KIND_MUL, KIND_NUM_DIV,
        KIND_DIV, KIND_BITWISE, KIND_XOR, KIND_OR_OR, KIND_OR, KIND_AND_AND,
        KIND_AND, KIND_EQ_EQ, KIND_EQ, KIND_NE, KIND_NOT, KIND_LSHIFT, KIND_LE,
        KIND_LESS, KIND_RSHIFT, KIND_GE, KIND_BIGGER, KIND_LPAREN, KIND_RPAREN,
        KIND_LBRACKET, KIND_RBRACKET, KIND_LBRACE, KIND_RBRACE, KIND_STRING,
        KIND_NUMBER, KIND_IDENT, KIND_COMMA, KIND_SEMICOLON, KIND_DOT, KIND_IF,
        KIND_ELSE, KIND_WHILE, KIND_CLASS, KIND_TRUE, KIND_FALSE, KIND_FOR,
        KIND_FUNC, KIND_NILL, KIND_EOL, KIND_EOF, KIND_ERROR
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_OP, MODE_DOT, MODE_STR, MODE_INT, MODE_FRAC,
        MODE_WORD, MODE_LINE, MODE_BLOCK, MODE_STAR
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } t_token;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic [15:0] clamp16(logic [32:0] v);
        return (|v[32:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_token make_token(t_kind k, logic [32:0] off, logic [32:0] len,
                                          logic [15:0] line);
        t_token t;
        t.kind   = k;
        t.offset = clamp16(off);
        t.length = clamp16(len);
        t.line   = line;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic t_kind single_op(logic [7:0] p);
        case (p)
            "*":     return KIND_MUL;
            "/":     return KIND_DIV;
            "|":     return KIND_OR;
            "&":     return KIND_AND;
            "=":     return KIND_EQ;
            "!":     return KIND_NOT;
            "<":     return KIND_LESS;
            ">":     return KIND_BIGGER;
            default: return KIND_ERROR;
        endcase
    endfunction

    // KIND_ERROR means no two-character operator
    function automatic t_kind pair_op(logic [7:0] p, logic [7:0] b);
        t_kind k;
        k = KIND_ERROR;
        case (p)
            "*": if (b == "*") k = KIND_POWER;
            "/": if (b == "/") k = KIND_NUM_DIV;
            "|": if (b == "|") k = KIND_OR_OR;
            "&": if (b == "&") k = KIND_AND_AND;
            "=": if (b == "=") k = KIND_EQ_EQ;
            "!": if (b == "=") k = KIND_NE;
            "<": begin
                if (b == "<") k = KIND_LSHIFT;
                else if (b == "=") k = KIND_LE;
            end
            ">": begin
                if (b == ">") k = KIND_RSHIFT;
                else if (b == "=") k = KIND_GE;
            end
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_kind one_char(logic [7:0] b);
        case (b)
            "+":     return KIND_ADD;
            "-":     return KIND_MINUS;
            "%":     return KIND_MODULE;
            "~":     return KIND_BITWISE;
            "^":     return KIND_XOR;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "[":     return KIND_LBRACKET;
            "]":     return KIND_RBRACKET;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            ",":     return KIND_COMMA;
            ";":     return KIND_SEMICOLON;
            default: return KIND_ERROR;
        endcase
    endfunction

    // w holds the first eight word bytes, byte 0 in the low bits
    function automatic t_kind word_kind(logic [63:0] w, logic [3:0] n);
        logic [7:0] c0, c1, c2, c3, c4, c5, c6, c7;
        t_kind k;
        c0 = w[7:0];   c1 = w[15:8];  c2 = w[23:16]; c3 = w[31:24];
        c4 = w[39:32]; c5 = w[47:40]; c6 = w[55:48]; c7 = w[63:56];
        k = KIND_IDENT;
        case (n)
            4'd2: begin
                if ({c0, c1} == "or") k = KIND_OR_OR;
                else if ({c0, c1} == "if") k = KIND_IF;
            end
            4'd3: begin
                if ({c0, c1, c2} == "and") k = KIND_AND_AND;
                else if ({c0, c1, c2} == "mod") k = KIND_MODULE;
                else if ({c0, c1, c2} == "not") k = KIND_NOT;
                else if ({c0, c1, c2} == "for") k = KIND_FOR;
                else if ({c0, c1, c2} == "fun") k = KIND_FUNC;
            end
            4'd4: begin
                if ({c0, c1, c2, c3} == "else") k = KIND_ELSE;
                else if ({c0, c1, c2, c3} == "true") k = KIND_TRUE;
                else if ({c0, c1, c2, c3} == "nill") k = KIND_NILL;
                else if ({c0, c1, c2, c3} == "func") k = KIND_FUNC;
            end
            4'd5: begin
                if ({c0, c1, c2, c3, c4} == "while") k = KIND_WHILE;
                else if ({c0, c1, c2, c3, c4} == "class") k = KIND_CLASS;
                else if ({c0, c1, c2, c3, c4} == "false") k = KIND_FALSE;
            end
            4'd8: begin
                if ({c0, c1, c2, c3, c4, c5, c6, c7} == "function") k = KIND_FUNC;
            end
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/stt_scanner.sv]
module stt_scanner #(
    parameter int POSITION_BITS   = stt_pkg::PositionBits,
    parameter int MAX_KEYWORD_LEN = stt_pkg::MaxKeywordLen
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_source_byte,
    input  logic             i_room,
    output logic [1:0]       o_push_cnt,
    output stt_pkg::t_token  o_tok [stt_pkg::MaxTokens]
);

    localparam int IW = $clog2(MAX_KEYWORD_LEN);

    logic                     r_in_valid;
    logic [7:0]               r_byte;
    stt_pkg::t_mode           r_mode, n_mode;
    logic [7:0]               r_pend, n_pend;
    logic [7:0]               r_quote, n_quote;
    logic [7:0]               r_word [MAX_KEYWORD_LEN];
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [15:0]              r_line, n_line;
    logic                     r_nl, n_nl;

    logic                     fire;
    logic                     do_idle;
    logic                     wr_en;
    logic [IW-1:0]            wr_idx;
    logic [POSITION_BITS-1:0] run;
    logic [63:0]              word_bits;
    stt_pkg::t_kind           wkind;
    stt_pkg::t_kind           two;
    logic [32:0]              pos33;
    logic [32:0]              start33;
    logic [32:0]              run33;
    stt_pkg::t_token          n_tok [stt_pkg::MaxTokens];
    logic [1:0]               n_cnt;

    assign fire    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign run     = r_pos - r_start;
    assign pos33   = 33'(r_pos);
    assign start33 = 33'(r_start);
    assign run33   = 33'(run);
    assign two     = stt_pkg::pair_op(r_pend, r_byte);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            word_bits[8*i +: 8] = r_word[i];
        end
    end

    assign wkind = (run > POSITION_BITS'(8)) ? stt_pkg::KIND_IDENT
                                              : stt_pkg::word_kind(word_bits, run[3:0]);

    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_quote = r_quote;
        n_start = r_start;
        n_pos   = r_pos;
        n_line  = r_line;
        n_nl    = r_nl;
        n_cnt   = 2'd0;
        do_idle = 1'b0;
        wr_en   = 1'b0;
        wr_idx  = run[IW-1:0];
        for (int i = 0; i < stt_pkg::MaxTokens; i++) begin
            n_tok[i] = '0;
        end

        if (r_byte == stt_pkg::CH_NUL) begin
            case (r_mode)
                stt_pkg::MODE_OP: begin
                    if (r_pend == "/" && r_nl) begin
                        n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_EOL, start33,
                                                           33'd0, r_line);
                        n_cnt = n_cnt + 2'd1;
                    end
                    n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::single_op(r_pend), start33,
                                                       33'd1, r_line);
                    n_cnt = n_cnt + 2'd1;
                end
                stt_pkg::MODE_DOT: begin
                    n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_DOT, start33, 33'd1,
                                                       r_line);
                    n_cnt = n_cnt + 2'd1;
                end
                stt_pkg::MODE_INT, stt_pkg::MODE_FRAC: begin
                    n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_NUMBER, start33, run33,
                                                       r_line);
                    n_cnt = n_cnt + 2'd1;
                end
                stt_pkg::MODE_WORD: begin
                    n_tok[n_cnt] = stt_pkg::make_token(wkind, start33, run33, r_line);
                    n_cnt = n_cnt + 2'd1;
                end
                stt_pkg::MODE_STR: begin
                    n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_ERROR, start33, run33,
                                                       r_line);
                    n_cnt = n_cnt + 2'd1;
                end
                default: begin
                    if (r_nl) begin
                        n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_EOL, pos33, 33'd0,
                                                           r_line);
                        n_cnt = n_cnt + 2'd1;
                    end
                end
            endcase
            n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_EOF, pos33, 33'd0, r_line);
            n_cnt   = n_cnt + 2'd1;
            n_mode  = stt_pkg::MODE_IDLE;
            n_pend  = '0;
            n_quote = '0;
            n_start = '0;
            n_pos   = '0;
            n_line  = 16'd1;
            n_nl    = 1'b0;
        end else begin
            case (r_mode)
                stt_pkg::MODE_OP: begin
                    if (r_pend == "/" && r_byte == "*") begin
                        n_mode = stt_pkg::MODE_BLOCK;
                    end else begin
                        if (r_pend == "/" && n_nl) begin
                            n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_EOL, start33,
                                                               33'd0, n_line);
                            n_cnt = n_cnt + 2'd1;
                            n_nl  = 1'b0;
                        end
                        if (two != stt_pkg::KIND_ERROR) begin
                            n_tok[n_cnt] = stt_pkg::make_token(two, start33, run33 + 33'd1,
                                                               n_line);
                            n_cnt  = n_cnt + 2'd1;
                            n_mode = stt_pkg::MODE_IDLE;
                        end else begin
                            n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::single_op(r_pend),
                                                               start33, 33'd1, n_line);
                            n_cnt   = n_cnt + 2'd1;
                            do_idle = 1'b1;
                        end
                    end
                end
                stt_pkg::MODE_DOT: begin
                    if (stt_pkg::is_digit(r_byte)) begin
                        n_mode = stt_pkg::MODE_FRAC;
                    end else begin
                        n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_DOT, start33, 33'd1,
                                                           n_line);
                        n_cnt   = n_cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_INT, stt_pkg::MODE_FRAC: begin
                    if (stt_pkg::is_digit(r_byte)) begin
                        n_mode = r_mode;
                    end else if (r_mode == stt_pkg::MODE_INT && r_byte == ".") begin
                        n_mode = stt_pkg::MODE_FRAC;
                    end else begin
                        n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_NUMBER, start33,
                                                           run33, n_line);
                        n_cnt   = n_cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_WORD: begin
                    if (stt_pkg::is_letter(r_byte)) begin
                        wr_en = (run < POSITION_BITS'(MAX_KEYWORD_LEN));
                    end else begin
                        n_tok[n_cnt] = stt_pkg::make_token(wkind, start33, run33, n_line);
                        n_cnt   = n_cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_STR: begin
                    if (r_byte == r_quote) begin
                        n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_STRING, start33,
                                                           run33 + 33'd1, n_line);
                        n_cnt  = n_cnt + 2'd1;
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_LINE: begin
                    if (r_byte == stt_pkg::CH_LF) begin
                        if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                        n_nl   = 1'b1;
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_BLOCK: begin
                    if (r_byte == "*") begin
                        n_mode = stt_pkg::MODE_STAR;
                    end else if (r_byte == stt_pkg::CH_LF) begin
                        if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                    end
                end
                stt_pkg::MODE_STAR: begin
                    if (r_byte == "/") begin
                        n_mode = stt_pkg::MODE_IDLE;
                    end else if (r_byte != "*") begin
                        if (r_byte == stt_pkg::CH_LF && n_line != 16'hFFFF) begin
                            n_line = n_line + 16'd1;
                        end
                        n_mode = stt_pkg::MODE_BLOCK;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            if (do_idle) begin
                n_mode = stt_pkg::MODE_IDLE;
                if (r_byte == stt_pkg::CH_SPACE || r_byte == stt_pkg::CH_TAB) begin
                    n_mode = stt_pkg::MODE_IDLE;
                end else if (r_byte == stt_pkg::CH_LF) begin
                    if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                    n_nl = 1'b1;
                end else if (r_byte == "#") begin
                    n_mode = stt_pkg::MODE_LINE;
                end else if (r_byte == "/") begin
                    n_mode  = stt_pkg::MODE_OP;
                    n_pend  = r_byte;
                    n_start = r_pos;
                end else begin
                    if (n_nl) begin
                        n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::KIND_EOL, pos33, 33'd0,
                                                           n_line);
                        n_cnt = n_cnt + 2'd1;
                        n_nl  = 1'b0;
                    end
                    case (r_byte) inside
                        "*", "|", "&", "=", "!", "<", ">": begin
                            n_mode  = stt_pkg::MODE_OP;
                            n_pend  = r_byte;
                            n_start = r_pos;
                        end
                        stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE: begin
                            n_mode  = stt_pkg::MODE_STR;
                            n_quote = r_byte;
                            n_start = r_pos;
                        end
                        ".": begin
                            n_mode  = stt_pkg::MODE_DOT;
                            n_start = r_pos;
                        end
                        ["0":"9"]: begin
                            n_mode  = stt_pkg::MODE_INT;
                            n_start = r_pos;
                        end
                        ["a":"z"], ["A":"Z"]: begin
                            n_mode  = stt_pkg::MODE_WORD;
                            n_start = r_pos;
                            wr_en   = 1'b1;
                            wr_idx  = '0;
                        end
                        default: begin
                            n_tok[n_cnt] = stt_pkg::make_token(stt_pkg::one_char(r_byte),
                                                               pos33, 33'd1, n_line);
                            n_cnt = n_cnt + 2'd1;
                        end
                    endcase
                end
            end

            if (r_pos != '1) n_pos = r_pos + POSITION_BITS'(1);
        end

        if (n_cnt != 2'd0) n_tok[n_cnt - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= stt_pkg::MODE_IDLE;
            r_pend     <= '0;
            r_quote    <= '0;
            r_start    <= '0;
            r_pos      <= '0;
            r_line     <= 16'd1;
            r_nl       <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_quote <= n_quote;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_line  <= n_line;
                r_nl    <= n_nl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_byte <= i_source_byte;
        if (fire && wr_en) r_word[wr_idx] <= r_byte;
    end

    assign o_push_cnt = fire ? n_cnt : 2'd0;
    assign o_tok      = n_tok;

endmodule

[hw/rtl/stt_token_fifo.sv]
module stt_token_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_cnt,
    input  stt_pkg::t_token i_tok [stt_pkg::MaxTokens],
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_stall,
    output stt_pkg::t_token o_tok
);

    localparam int Depth = 8;
    localparam int AW    = $clog2(Depth);

    stt_pkg::t_token r_mem [Depth];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= (AW+1)'(Depth - stt_pkg::MaxTokens));
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push_cnt);
            if (pop) r_rd <= r_rd + AW'(1);
            r_count <= r_count + (AW+1)'(i_push_cnt) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < stt_pkg::MaxTokens; i++) begin
            if (2'(i) < i_push_cnt) r_mem[r_wr + AW'(i)] <= i_tok[i];
        end
    end

endmodule

[hw/rtl/source_text_tokenizer.sv]
// Streaming tokenizer: one source byte per beat on the input channel, tokens out one per
// beat. A byte is registered, then scanned against the scanner state, and its zero to
// three tokens are written into an eight-entry token queue; a new byte is taken every
// cycle while the queue has room for three more tokens, so the input rate is one byte
// per cycle and the output rate is one token per cycle unless i_stall is set. Byte zero
// ends the source, flushes any open token, emits end-of-file and restarts the scanner.
module source_text_tokenizer #(
    parameter int POSITION_BITS   = stt_pkg::PositionBits,
    parameter int MAX_KEYWORD_LEN = stt_pkg::MaxKeywordLen
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_token_offset,
    output logic [15:0] o_token_length,
    output logic [15:0] o_line_number,
    output logic        o_last_of_run
);

    logic            room;
    logic [1:0]      push_cnt;
    stt_pkg::t_token tok [stt_pkg::MaxTokens];
    stt_pkg::t_token head;

    stt_scanner #(
        .POSITION_BITS   (POSITION_BITS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_source_byte (i_source_byte),
        .i_room        (room),
        .o_push_cnt    (push_cnt),
        .o_tok         (tok)
    );

    stt_token_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_tok      (tok),
        .o_room     (room),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_tok      (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_offset = head.offset;
    assign o_token_length = head.length;
    assign o_line_number  = head.line;
    assign o_last_of_run  = head.last;

endmodule
